### rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and codes for the Morse sequence player.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

	localparam int SEQ_DEPTH_DEF = 64;

	localparam int REQ_TYPE_W = 2;
	localparam int IDX_IN_W   = 6;
	localparam int IDX_RANGE  = 1 << IDX_IN_W;
	localparam int ELEM_W     = 3;
	localparam int ERR_W      = 2;
	localparam int DIT_W      = 15;
	localparam int IVL_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIT_W;

	localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_PLAY = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_STOP = 2'd2;
	localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 2'd3;

	localparam logic [ELEM_W-1:0] ELEM_END       = 3'd0;
	localparam logic [ELEM_W-1:0] ELEM_DIT_TONE  = 3'd1;
	localparam logic [ELEM_W-1:0] ELEM_DAH_TONE  = 3'd2;
	localparam logic [ELEM_W-1:0] ELEM_DIT_PAUSE = 3'd3;
	localparam logic [ELEM_W-1:0] ELEM_DAH_PAUSE = 3'd4;

	localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_START   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_INVALID = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_FAST_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_DIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DIT  = 2'd2;

	localparam logic [DIT_W-1:0] FAST_DIT_RESET = 15'd60;
	localparam logic [DIT_W-1:0] SLOW_DIT_RESET = 15'd100;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [IDX_IN_W-1:0]   start_index;
		logic [IDX_IN_W-1:0]   load_index;
		logic [ELEM_W-1:0]     load_element;
	} req_t;

	typedef struct packed {
		logic             key_on;
		logic             key_notify;
		logic             playing;
		logic [ERR_W-1:0] error;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/core/msp_req_if.sv
// ----------------------------------------------------------------------------
// msp_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_req_if;
	logic          valid;
	logic          ready;
	msp_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/msp_rsp_if.sv
// ----------------------------------------------------------------------------
// msp_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_rsp_if;
	logic          valid;
	logic          ready;
	msp_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/morse_sequence_player_core.sv
// ----------------------------------------------------------------------------
// morse_sequence_player_core
// Tick-driven Morse keyer playing a looping tone/pause sequence from a store.
// ----------------------------------------------------------------------------
// Takes one item per clock; stage one registers the item and the result
// register its result. The store is read at the accepting edge (a two-port
// registered-read memory, prefetching the current and the start element with
// write forwarding); stage one updates the player and loads the result
// register once it is free. Throughput is set by that single state-update
// stage: one item per cycle while the result side keeps taking items.
`default_nettype none

module morse_sequence_player_core #(
	parameter int SEQ_DEPTH = msp_pkg::SEQ_DEPTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	msp_req_if.sink                          req,
	msp_rsp_if.source                        rsp,
	input  wire                              cfg_we,
	input  wire [msp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [msp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int AW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;

	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_INTERVAL = 2'd1;
	localparam logic [1:0] MODE_TAKE     = 2'd2;

	// configuration
	logic                        fast_mode_q;
	logic [msp_pkg::DIT_W-1:0]   fast_dit_q;
	logic [msp_pkg::DIT_W-1:0]   slow_dit_q;

	// player state
	logic [1:0]                  mode_q, mode_d;
	logic [msp_pkg::IVL_W-1:0]   left_q, left_d;
	logic [AW-1:0]               cur_q, cur_d;
	logic [AW-1:0]               start_q, start_d;
	logic                        key_q, key_d;

	// input stage
	logic                        v_s1;
	msp_pkg::req_t               req_s1;
	logic [msp_pkg::ELEM_W-1:0]  rd_a_s1;
	logic [msp_pkg::ELEM_W-1:0]  rd_b_s1;

	// result register
	logic                        rsp_v_q;
	msp_pkg::rsp_t               rsp_q;

	logic [msp_pkg::ELEM_W-1:0]  mem [SEQ_DEPTH];
	logic [AW-1:0]               idx_mod [msp_pkg::IDX_RANGE];

	logic                        fire_s1;
	logic                        in_fire;
	logic                        mem_we;
	logic [AW-1:0]               waddr;
	logic [AW-1:0]               raddr_a;
	logic [AW-1:0]               raddr_b;
	logic                        notify;
	logic [msp_pkg::ERR_W-1:0]   err;

	logic [msp_pkg::ELEM_W-1:0]  el_take;
	logic [AW-1:0]               take_base;
	logic [AW-1:0]               take_next;
	logic [msp_pkg::DIT_W-1:0]   dit_sel;
	logic [msp_pkg::IVL_W:0]     dah_full;
	logic [msp_pkg::IVL_W-1:0]   dah_sat;
	logic [msp_pkg::IVL_W-1:0]   ivl_take;

	// index reduction modulo the store depth
	for (genvar g = 0; g < msp_pkg::IDX_RANGE; g++) begin : g_mod
		assign idx_mod[g] = AW'(g % SEQ_DEPTH);
	end

	assign fire_s1   = v_s1 && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1 || fire_s1;
	assign in_fire   = req.valid && req.ready;

	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	// element fetch for a tick in take-next mode
	assign el_take   = (rd_a_s1 == msp_pkg::ELEM_END) ? rd_b_s1 : rd_a_s1;
	assign take_base = (rd_a_s1 == msp_pkg::ELEM_END) ? start_q : cur_q;
	assign take_next = (take_base == AW'(SEQ_DEPTH - 1)) ? '0 : take_base + 1'b1;

	assign dit_sel  = fast_mode_q ? fast_dit_q : slow_dit_q;
	assign dah_full = {2'b00, dit_sel} + {1'b0, dit_sel, 1'b0};
	assign dah_sat  = dah_full[msp_pkg::IVL_W] ? '1 : dah_full[msp_pkg::IVL_W-1:0];

	always_comb begin
		case (el_take) inside
			msp_pkg::ELEM_DIT_TONE, msp_pkg::ELEM_DIT_PAUSE: ivl_take = {1'b0, dit_sel};
			msp_pkg::ELEM_DAH_TONE, msp_pkg::ELEM_DAH_PAUSE: ivl_take = dah_sat;
			default:                                         ivl_take = '0;
		endcase
	end

	assign waddr = idx_mod[req_s1.load_index];

	always_comb begin
		mode_d  = mode_q;
		left_d  = left_q;
		cur_d   = cur_q;
		start_d = start_q;
		key_d   = key_q;
		notify  = 1'b0;
		err     = msp_pkg::ERR_NONE;
		mem_we  = 1'b0;
		if (fire_s1) begin
			case (req_s1.req_type)
				msp_pkg::REQ_LOAD: begin
					mem_we = 1'b1;
				end
				msp_pkg::REQ_STOP: begin
					key_d  = 1'b0;
					notify = 1'b1;
					mode_d = MODE_IDLE;
				end
				msp_pkg::REQ_PLAY: begin
					start_d = idx_mod[req_s1.start_index];
					cur_d   = idx_mod[req_s1.start_index];
					if (rd_a_s1 == msp_pkg::ELEM_END) begin
						err    = msp_pkg::ERR_START;
						key_d  = 1'b0;
						notify = 1'b1;
						mode_d = MODE_IDLE;
					end else begin
						mode_d = MODE_TAKE;
					end
				end
				default: begin
					if (mode_q == MODE_INTERVAL) begin
						if (left_q == '0) begin
							mode_d = MODE_TAKE;
						end else begin
							left_d = left_q - 1'b1;
						end
					end else if (mode_q == MODE_TAKE) begin
						if (el_take > msp_pkg::ELEM_DAH_PAUSE) begin
							cur_d  = take_base;
							err    = msp_pkg::ERR_INVALID;
							key_d  = 1'b0;
							notify = 1'b1;
							mode_d = MODE_IDLE;
						end else begin
							case (el_take) inside
								msp_pkg::ELEM_DIT_TONE, msp_pkg::ELEM_DAH_TONE: begin
									key_d  = 1'b1;
									notify = 1'b1;
								end
								msp_pkg::ELEM_DIT_PAUSE, msp_pkg::ELEM_DAH_PAUSE: begin
									key_d  = 1'b0;
									notify = 1'b1;
								end
								default: begin
									key_d = key_q;
								end
							endcase
							left_d = ivl_take;
							cur_d  = take_next;
							mode_d = MODE_INTERVAL;
						end
					end
				end
			endcase
		end
	end

	// prefetch addresses follow the state left by the item now in stage one
	assign raddr_a = (req.data.req_type == msp_pkg::REQ_PLAY) ?
		idx_mod[req.data.start_index] : cur_d;
	assign raddr_b = start_d;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= req_s1.load_element;
		end
		if (in_fire) begin
			req_s1  <= req.data;
			rd_a_s1 <= (mem_we && waddr == raddr_a) ? req_s1.load_element : mem[raddr_a];
			rd_b_s1 <= (mem_we && waddr == raddr_b) ? req_s1.load_element : mem[raddr_b];
		end
		if (fire_s1) begin
			rsp_q.key_on     <= key_d;
			rsp_q.key_notify <= notify;
			rsp_q.playing    <= (mode_d != MODE_IDLE);
			rsp_q.error      <= err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			rsp_v_q <= 1'b0;
			mode_q  <= MODE_IDLE;
			left_q  <= '0;
			cur_q   <= '0;
			start_q <= '0;
			key_q   <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= req.valid;
			end
			if (fire_s1) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			mode_q  <= mode_d;
			left_q  <= left_d;
			cur_q   <= cur_d;
			start_q <= start_d;
			key_q   <= key_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_mode_q <= 1'b0;
			fast_dit_q  <= msp_pkg::FAST_DIT_RESET;
			slow_dit_q  <= msp_pkg::SLOW_DIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				msp_pkg::CFG_FAST_MODE: fast_mode_q <= cfg_wdata[0];
				msp_pkg::CFG_FAST_DIT:  fast_dit_q  <= cfg_wdata;
				msp_pkg::CFG_SLOW_DIT:  slow_dit_q  <= cfg_wdata;
				default: begin
					fast_mode_q <= fast_mode_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks on the result channel of the Morse sequence player.
// ----------------------------------------------------------------------------
`default_nettype none

module msp_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                rsp_valid,
	input wire                rsp_ready,
	input wire msp_pkg::rsp_t rsp_data
);

	// an error always drops the key and halts the player
	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.error != msp_pkg::ERR_NONE |->
		!rsp_data.key_on && rsp_data.key_notify && !rsp_data.playing)
		else $error("error item without key off and halt");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.error == msp_pkg::ERR_NONE ||
		rsp_data.error == msp_pkg::ERR_START || rsp_data.error == msp_pkg::ERR_INVALID)
		else $error("undefined error code");

	// idle is only reached with the key cleared
	a_key_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.key_on |-> rsp_data.playing)
		else $error("key on while idle");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result item changed");

endmodule

bind morse_sequence_player_core msp_checker u_msp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

### tb/morse_sequence_player_core_tb.sv
// ----------------------------------------------------------------------------
// morse_sequence_player_core_tb
// Self-checking bench for the Morse sequence player core.
// ----------------------------------------------------------------------------
// Fills the sequence store, then drives directed cases for each request kind:
// halts, index wrap, rewind onto an end, restart while playing, zero dit and
// a saturated dah. Random phases follow under changing dit settings.
// A scoreboard mirrors the player state, predicts one result per accepted
// item and compares each result with the oldest prediction. Both handshake
// sides idle in random bursts.

typedef enum logic [1:0] {
	PLAYER_IDLE,
	PLAYER_INTERVAL,
	PLAYER_TAKE
} player_mode_t;

class keyer_checker;
	logic                           fast_sel;
	logic [msp_pkg::DIT_W-1:0]      fast_dit;
	logic [msp_pkg::DIT_W-1:0]      slow_dit;
	player_mode_t                   mode;
	logic [msp_pkg::IVL_W-1:0]      ivl_left;
	logic [msp_pkg::IDX_IN_W-1:0]   cur_idx;
	logic [msp_pkg::IDX_IN_W-1:0]   seq_start;
	logic                           key;
	logic [msp_pkg::ELEM_W-1:0]     store [msp_pkg::SEQ_DEPTH_DEF];
	msp_pkg::rsp_t                  awaited_keying [$];
	int fails;
	int shown;
	int n_items;
	int n_plays;
	int n_err_start;
	int n_err_invalid;
	int n_key_writes;

	function new();
		fast_sel = 1'b0;
		fast_dit = msp_pkg::FAST_DIT_RESET;
		slow_dit = msp_pkg::SLOW_DIT_RESET;
		mode = PLAYER_IDLE;
		ivl_left = '0;
		cur_idx = '0;
		seq_start = '0;
		key = 1'b0;
		foreach (store[i]) store[i] = msp_pkg::ELEM_END;
		fails = 0;
		shown = 0;
		n_items = 0;
		n_plays = 0;
		n_err_start = 0;
		n_err_invalid = 0;
		n_key_writes = 0;
	endfunction

	function logic [msp_pkg::IVL_W-1:0] element_ticks(logic [msp_pkg::ELEM_W-1:0] el);
		logic [17:0] len;
		len = {3'b000, fast_sel ? fast_dit : slow_dit};
		if (el == msp_pkg::ELEM_DAH_TONE || el == msp_pkg::ELEM_DAH_PAUSE) begin
			len = len * 18'd3;
		end else if (el != msp_pkg::ELEM_DIT_TONE && el != msp_pkg::ELEM_DIT_PAUSE) begin
			len = '0;
		end
		return (len > 18'h0FFFF) ? 16'hFFFF : len[15:0];
	endfunction

	function void note_request(msp_pkg::req_t r);
		msp_pkg::rsp_t want;
		logic [msp_pkg::ELEM_W-1:0] el;
		want = '0;
		n_items++;
		case (r.req_type)
			msp_pkg::REQ_LOAD: begin
				store[r.load_index] = r.load_element;
			end
			msp_pkg::REQ_STOP: begin
				key = 1'b0;
				want.key_notify = 1'b1;
				mode = PLAYER_IDLE;
			end
			msp_pkg::REQ_PLAY: begin
				n_plays++;
				seq_start = r.start_index;
				cur_idx = r.start_index;
				if (store[r.start_index] == msp_pkg::ELEM_END) begin
					want.error = msp_pkg::ERR_START;
					key = 1'b0;
					want.key_notify = 1'b1;
					mode = PLAYER_IDLE;
				end else begin
					mode = PLAYER_TAKE;
				end
			end
			default: begin
				if (mode == PLAYER_INTERVAL) begin
					if (ivl_left == '0) mode = PLAYER_TAKE;
					else ivl_left = ivl_left - 1'b1;
				end else if (mode == PLAYER_TAKE) begin
					el = store[cur_idx];
					if (el == msp_pkg::ELEM_END) begin
						cur_idx = seq_start;
						el = store[cur_idx];
					end
					if (el > msp_pkg::ELEM_DAH_PAUSE) begin
						want.error = msp_pkg::ERR_INVALID;
						key = 1'b0;
						want.key_notify = 1'b1;
						mode = PLAYER_IDLE;
					end else begin
						if (el == msp_pkg::ELEM_DIT_TONE || el == msp_pkg::ELEM_DAH_TONE) begin
							key = 1'b1;
							want.key_notify = 1'b1;
						end else if (el == msp_pkg::ELEM_DIT_PAUSE ||
								el == msp_pkg::ELEM_DAH_PAUSE) begin
							key = 1'b0;
							want.key_notify = 1'b1;
						end
						ivl_left = element_ticks(el);
						cur_idx = cur_idx + 1'b1;
						mode = PLAYER_INTERVAL;
					end
				end
			end
		endcase
		want.key_on = key;
		want.playing = (mode != PLAYER_IDLE);
		if (want.error == msp_pkg::ERR_START) n_err_start++;
		if (want.error == msp_pkg::ERR_INVALID) n_err_invalid++;
		if (want.key_notify) n_key_writes++;
		awaited_keying.push_back(want);
	endfunction

	function void check_result(msp_pkg::rsp_t got);
		msp_pkg::rsp_t want;
		if (awaited_keying.size() == 0) begin
			fails++;
			if (shown < 100) begin
				$display("%0t: unexpected result key_on=%0b notify=%0b playing=%0b error=%0d",
					$time, got.key_on, got.key_notify, got.playing, got.error);
			end
			shown++;
			return;
		end
		want = awaited_keying.pop_front();
		if (got.key_on !== want.key_on || got.key_notify !== want.key_notify ||
				got.playing !== want.playing || got.error !== want.error) begin
			fails++;
			if (shown < 100) begin
				$display("%0t: mismatch expected key_on=%0b notify=%0b playing=%0b error=%0d, %s",
					$time, want.key_on, want.key_notify, want.playing, want.error, "actual");
				$display("%0t:          actual   key_on=%0b notify=%0b playing=%0b error=%0d",
					$time, got.key_on, got.key_notify, got.playing, got.error);
			end
			shown++;
		end
	endfunction
endclass

module morse_sequence_player_core_tb;

	localparam int DEPTH       = msp_pkg::SEQ_DEPTH_DEF;
	localparam int TAIL_CYCLES = 8;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 280;
	localparam int IW          = msp_pkg::IDX_IN_W;
	localparam int EW          = msp_pkg::ELEM_W;
	localparam int DW          = msp_pkg::DIT_W;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [msp_pkg::CFG_DATA_W-1:0] cfg_wdata;
	bit                             gaps_on;
	int                             n_settings;

	keyer_checker sb = new();

	msp_req_if req();
	msp_rsp_if rsp();

	morse_sequence_player_core #(
		.SEQ_DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) sb.note_request(req.data);
			if (rsp.valid && rsp.ready) sb.check_result(rsp.data);
		end
	end

	initial begin : result_sink
		int left;
		left = 0;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0) begin
				if (gaps_on && $urandom_range(0, 3) == 0) begin
					rsp.ready <= 1'b0;
					left = $urandom_range(1, 16);
				end else begin
					rsp.ready <= 1'b1;
					left = $urandom_range(1, 40);
				end
			end else begin
				left--;
			end
		end
	end

	initial begin : watchdog
		#3000000;
		$display("FAIL morse_sequence_player_core");
		$finish;
	end

	function automatic msp_pkg::req_t make_req(logic [msp_pkg::REQ_TYPE_W-1:0] kind,
			logic [IW-1:0] start, logic [IW-1:0] lidx, logic [EW-1:0] el);
		msp_pkg::req_t r;
		r.req_type = kind;
		r.start_index = start;
		r.load_index = lidx;
		r.load_element = el;
		return r;
	endfunction

	task automatic send_item(input msp_pkg::req_t r);
		int gap;
		gap = 0;
		if (gaps_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 16);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic load_elem(input logic [IW-1:0] idx, input logic [EW-1:0] el);
		send_item(make_req(msp_pkg::REQ_LOAD, IW'($urandom), idx, el));
	endtask

	task automatic play_from(input logic [IW-1:0] idx);
		send_item(make_req(msp_pkg::REQ_PLAY, idx, IW'($urandom), EW'($urandom)));
	endtask

	task automatic stop_play();
		send_item(make_req(msp_pkg::REQ_STOP, IW'($urandom), IW'($urandom), EW'($urandom)));
	endtask

	task automatic ticks(input int n);
		repeat (n) send_item(make_req(msp_pkg::REQ_TICK, '0, '0, '0));
	endtask

	// lower valid and wait for every predicted result, then an optional tail
	task automatic settle(input int tail);
		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.awaited_keying.size() != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic set_config(input logic fast, input logic [DW-1:0] fdit,
			input logic [DW-1:0] sdit);
		settle(TAIL_CYCLES);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= msp_pkg::CFG_FAST_MODE;
		cfg_wdata <= msp_pkg::CFG_DATA_W'(fast);
		@(negedge clk);
		cfg_index <= msp_pkg::CFG_FAST_DIT;
		cfg_wdata <= fdit;
		@(negedge clk);
		cfg_index <= msp_pkg::CFG_SLOW_DIT;
		cfg_wdata <= sdit;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.fast_sel = fast;
		sb.fast_dit = fdit;
		sb.slow_dit = sdit;
		n_settings++;
	endtask

	function automatic logic [DW-1:0] pick_dit();
		int p;
		p = $urandom_range(0, 19);
		case (p)
			0: return '0;
			1: return DW'(21845);
			2: return DW'(32767);
			3: return DW'($urandom_range(1, 32767));
			default: return DW'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [EW-1:0] pick_element();
		int p;
		p = $urandom_range(0, 99);
		if (p < 86) return EW'($urandom_range(1, 4));
		if (p < 93) return msp_pkg::ELEM_END;
		return EW'($urandom_range(5, 7));
	endfunction

	task automatic random_item();
		msp_pkg::req_t r;
		int p;
		r.start_index = IW'($urandom);
		r.load_index = IW'($urandom);
		r.load_element = EW'($urandom);
		p = $urandom_range(0, 99);
		if (p < 75) begin
			r.req_type = msp_pkg::REQ_TICK;
		end else if (p < 89) begin
			r.req_type = msp_pkg::REQ_LOAD;
			r.load_element = pick_element();
		end else if (p < 97) begin
			r.req_type = msp_pkg::REQ_PLAY;
		end else begin
			r.req_type = msp_pkg::REQ_STOP;
		end
		send_item(r);
	endtask

	// a short valid sequence closed by an end, played from its first element
	task automatic well_formed_run();
		logic [IW-1:0] s;
		int len;
		s = IW'($urandom);
		len = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			load_elem(s + IW'(i), EW'($urandom_range(1, 4)));
		end
		load_elem(s + IW'(len), msp_pkg::ELEM_END);
		play_from(s);
		ticks($urandom_range(8, 40));
	endtask

	initial begin : stimulus
		int phase_end;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		gaps_on = 1'b1;
		n_settings = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// every store entry gets written before anything plays
		for (int i = 0; i < DEPTH; i++) begin
			load_elem(IW'(i), ($urandom_range(0, 7) == 0) ? msp_pkg::ELEM_END :
				EW'($urandom_range(1, 4)));
		end

		set_config(1'b1, DW'(1), DW'(2));
		stop_play();
		ticks(1);
		load_elem(6'd10, msp_pkg::ELEM_END);
		play_from(6'd10);
		load_elem(6'd20, msp_pkg::ELEM_DIT_TONE);
		load_elem(6'd21, msp_pkg::ELEM_DAH_PAUSE);
		load_elem(6'd22, msp_pkg::ELEM_END);
		play_from(6'd20);
		ticks(8);
		play_from(6'd20);
		load_elem(6'd20, msp_pkg::ELEM_END);
		ticks(3);
		load_elem(6'd30, 3'd7);
		play_from(6'd30);
		ticks(1);
		load_elem(6'd63, msp_pkg::ELEM_DAH_TONE);
		load_elem(6'd0, msp_pkg::ELEM_END);
		play_from(6'd63);
		ticks(6);
		load_elem(6'd30, 3'd5);
		play_from(6'd30);
		ticks(1);

		// zero dit, then a dah whose three dits pass the interval range;
		// a wrapped interval would hold a tick count of only two
		set_config(1'b1, '0, DW'(21846));
		load_elem(6'd40, msp_pkg::ELEM_DAH_TONE);
		load_elem(6'd41, msp_pkg::ELEM_DIT_PAUSE);
		load_elem(6'd42, msp_pkg::ELEM_END);
		play_from(6'd40);
		ticks(6);
		set_config(1'b0, '0, DW'(21846));
		play_from(6'd40);
		ticks(8);
		stop_play();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_config(1'b0, DW'(21845), DW'(1));
				1: set_config(1'b1, DW'(1), DW'(21845));
				default: set_config(1'($urandom), pick_dit(), pick_dit());
			endcase
			gaps_on = (ph != 2 && ph != PHASES - 1);
			phase_end = sb.n_items + PHASE_ITEMS;
			while (sb.n_items < phase_end) begin
				if ($urandom_range(0, 99) < 5) well_formed_run();
				else random_item();
				if ($urandom_range(0, 99) == 0) settle(0);
			end
		end

		settle(TAIL_CYCLES);
		$display("covered %0d items under %0d dit settings: fill, directed halts, wrap, rewind",
			sb.n_items, n_settings);
		$display("and a saturated dah; %0d plays, %0d start errors, %0d invalid halts, %0d key writes",
			sb.n_plays, sb.n_err_start, sb.n_err_invalid, sb.n_key_writes);
		if (sb.fails == 0 && sb.awaited_keying.size() == 0) begin
			$display("PASS morse_sequence_player_core");
		end else begin
			$display("FAIL morse_sequence_player_core");
		end
		$finish;
	end
endmodule
